// ----- rtl/knmh_pkg.sv -----
`default_nettype none

package knmh_pkg;

  localparam int unsigned HeapSize = 8;
  localparam int unsigned DistW    = 32;
  localparam int unsigned PointW   = 16;
  localparam int unsigned IdxW     = (HeapSize > 1) ? $clog2(HeapSize) : 1;
  localparam int unsigned ChildW   = $clog2(2 * HeapSize + 1);

  localparam logic [ChildW-1:0] HeapSizeC = ChildW'(HeapSize);
  localparam logic [IdxW-1:0]   LastIdx   = IdxW'(HeapSize - 1);
  localparam logic [DistW-1:0]  DistHuge  = {DistW{1'b1}};

  typedef struct packed {
    logic [DistW-1:0]  distance;
    logic [PointW-1:0] point;
  } knmh_entry_t;

  localparam int unsigned EntryW = $bits(knmh_entry_t);

  typedef enum logic [2:0] {
    StIdle,
    StRootRd,
    StRootCmp,
    StLeftRd,
    StRightRd,
    StCmp,
    StPlace,
    StDump
  } knmh_state_e;

endpackage

`default_nettype wire

// ----- rtl/knmh_ram.sv -----
`default_nettype none

module knmh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/k_nearest_max_heap.sv -----
// Keeps the HeapSize smallest candidate distances of a query in a max-heap held in a
// single-port-read RAM. A candidate is taken when start is high and busy is low; busy
// then stays high while the state machine walks the heap: a root read and compare, then
// per level of sift-down a left read, a right read and a compare and write, and a final
// write to place the candidate when the hole reaches a leaf; a rejected candidate ends
// after the root compare. An item with query_end then streams the HeapSize slots in
// heap order, one per cycle on strobe_o with final_entry_o on the last; the receiver
// cannot stall and must take every strobed result.
`default_nettype none

module k_nearest_max_heap
  import knmh_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DistW-1:0]  cand_distance_i,
  input  wire logic [PointW-1:0] cand_point_i,
  input  wire logic              query_start_i,
  input  wire logic              query_end_i,
  output logic                   strobe_o,
  output logic      [DistW-1:0]  neighbour_distance_o,
  output logic      [PointW-1:0] neighbour_point_o,
  output logic                   final_entry_o
);

  knmh_state_e state_q, state_d;

  logic [DistW-1:0]  cand_dist_q;
  logic [PointW-1:0] cand_point_q;
  logic              end_q;
  logic [IdxW-1:0]   hole_q, hole_d;
  logic [ChildW-1:0] child_q, child_d;
  logic [IdxW-1:0]   cnt_q, cnt_d;
  knmh_entry_t       left_q;
  logic [HeapSize-1:0] valid_q;
  logic              rvalid_q;
  logic              strobe_q;
  logic              last_q;

  logic              accept;
  logic              we;
  logic [IdxW-1:0]   waddr;
  knmh_entry_t       wdata;
  logic [IdxW-1:0]   raddr;
  logic [EntryW-1:0] ram_rdata;
  knmh_entry_t       rd;
  knmh_entry_t       cand;
  knmh_entry_t       chosen;
  logic [ChildW-1:0] right_idx;
  logic [ChildW-1:0] sel_idx;
  logic [ChildW-1:0] next_child;
  logic              has_right;
  logic              take_right;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  assign cand.distance = cand_dist_q;
  assign cand.point    = cand_point_q;

  always_comb begin
    rd = knmh_entry_t'(ram_rdata);
    if (!rvalid_q) begin
      rd.distance = DistHuge;
      rd.point    = '0;
    end
  end

  assign right_idx  = child_q + ChildW'(1);
  assign has_right  = (right_idx < HeapSizeC);
  assign take_right = has_right && (left_q.distance < rd.distance);
  assign chosen     = take_right ? rd : left_q;
  assign sel_idx    = take_right ? right_idx : child_q;
  assign next_child = {sel_idx[ChildW-2:0], 1'b1};

  knmh_ram #(
    .Width (EntryW),
    .Depth (HeapSize)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    hole_d  = hole_q;
    child_d = child_q;
    cnt_d   = cnt_q;
    we      = 1'b0;
    waddr   = hole_q;
    wdata   = cand;
    raddr   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRootRd;
        end
      end
      StRootRd: begin
        raddr   = '0;
        state_d = StRootCmp;
      end
      StRootCmp: begin
        hole_d = '0;
        cnt_d  = '0;
        if (cand_dist_q < rd.distance) begin
          if (HeapSize > 1) begin
            child_d = ChildW'(1);
            state_d = StLeftRd;
          end else begin
            we      = 1'b1;
            waddr   = '0;
            state_d = end_q ? StDump : StIdle;
          end
        end else begin
          state_d = end_q ? StDump : StIdle;
        end
      end
      StLeftRd: begin
        raddr   = child_q[IdxW-1:0];
        state_d = StRightRd;
      end
      StRightRd: begin
        raddr   = right_idx[IdxW-1:0];
        state_d = StCmp;
      end
      StCmp: begin
        we = 1'b1;
        if (cand_dist_q > chosen.distance) begin
          state_d = end_q ? StDump : StIdle;
        end else begin
          wdata  = chosen;
          hole_d = sel_idx[IdxW-1:0];
          child_d = next_child;
          state_d = (next_child < HeapSizeC) ? StLeftRd : StPlace;
        end
      end
      StPlace: begin
        we      = 1'b1;
        state_d = end_q ? StDump : StIdle;
      end
      StDump: begin
        raddr = cnt_q;
        if (cnt_q == LastIdx) begin
          state_d = StIdle;
        end else begin
          cnt_d = cnt_q + IdxW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      hole_q   <= '0;
      child_q  <= '0;
      cnt_q    <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      hole_q   <= hole_d;
      child_q  <= child_d;
      cnt_q    <= cnt_d;
      rvalid_q <= valid_q[raddr];
      strobe_q <= (state_q == StDump);
      last_q   <= (state_q == StDump) && (cnt_q == LastIdx);
      if (accept) begin
        end_q <= query_end_i;
      end
      if (accept && query_start_i) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  // candidate payload and left child capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_dist_q  <= cand_distance_i;
      cand_point_q <= cand_point_i;
    end
    if (state_q == StRightRd) begin
      left_q <= rd;
    end
  end

  assign strobe_o             = strobe_q;
  assign final_entry_o        = last_q;
  assign neighbour_distance_o = rd.distance;
  assign neighbour_point_o    = rd.point;

endmodule

`default_nettype wire

// ----- rtl/knmh_checker.sv -----
`default_nettype none

module knmh_sva
  import knmh_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic strobe_o,
  input wire logic final_entry_o
);

  // last flag only rides on a transfer
  a_final_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_entry_o |-> strobe_o)
    else $error("final_entry_o without strobe_o");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted item");

  // readout run has no gaps
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !final_entry_o) |=> strobe_o)
    else $error("gap inside readout run");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_entry_o |=> !strobe_o)
    else $error("transfer right after last entry");

  a_run_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !$past(strobe_o)) |-> $past(busy))
    else $error("readout run started while idle");

endmodule

bind k_nearest_max_heap knmh_sva u_knmh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .strobe_o      (strobe_o),
  .final_entry_o (final_entry_o)
);

`default_nettype wire
